### rtl/core/skc_pkg.sv
// ----------------------------------------------------------------------------
// skc_pkg
// Shared types and codes for the sorted key table.
// ----------------------------------------------------------------------------
package skc_pkg;

	localparam int unsigned DEPTH_DEF    = 64;
	localparam int unsigned KEY_BITS_DEF = 32;

	localparam int unsigned CMD_BITS    = 2;
	localparam int unsigned KEY_W       = 32;
	localparam int unsigned INDEX_BITS  = 6;
	localparam int unsigned STATUS_BITS = 3;
	localparam int unsigned POS_BITS    = 6;
	localparam int unsigned ENTRY_BITS  = 7;

	localparam int unsigned IN_BITS  = 40;
	localparam int unsigned OUT_BITS = 16;

	localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_FIND   = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd2;

	localparam logic [STATUS_BITS-1:0] STS_DONE      = 3'd0;
	localparam logic [STATUS_BITS-1:0] STS_FOUND     = 3'd1;
	localparam logic [STATUS_BITS-1:0] STS_NOT_FOUND = 3'd2;
	localparam logic [STATUS_BITS-1:0] STS_FULL      = 3'd3;
	localparam logic [STATUS_BITS-1:0] STS_BAD_INDEX = 3'd4;
	localparam logic [STATUS_BITS-1:0] STS_ZERO_KEY  = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_UPD  = 2'b10
	} skc_state_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} skc_ctrl_t;

endpackage

### rtl/core/skc_cell.sv
// ----------------------------------------------------------------------------
// skc_cell
// One table entry: holds a key and its valid flag, compares against the
// incoming key and shifts to or from its neighbours on insert and delete.
// ----------------------------------------------------------------------------
module skc_cell #(
	parameter int unsigned KEY_BITS = skc_pkg::KEY_BITS_DEF,
	parameter int unsigned CELL_IDX = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  skc_pkg::skc_ctrl_t                ctrl,
	input  logic [KEY_BITS-1:0]               cmp_key,
	input  logic [skc_pkg::INDEX_BITS-1:0]    del_index,
	input  logic [KEY_BITS-1:0]               ins_key,
	input  logic [KEY_BITS-1:0]               left_key,
	input  logic                              left_valid,
	input  logic                              left_lt,
	input  logic [KEY_BITS-1:0]               right_key,
	input  logic                              right_valid,
	output logic [KEY_BITS-1:0]               key,
	output logic                              valid,
	output logic                              lt,
	output logic                              eq
);
	import skc_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic                valid_q;
	logic                lt_q;
	logic                eq_q;
	logic                ge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
			ge_q    <= 1'b0;
		end else begin
			if (ctrl.cmp) begin
				lt_q <= valid_q && (key_q < cmp_key);
				eq_q <= valid_q && (key_q == cmp_key);
				ge_q <= (CELL_IDX >= 32'(del_index));
			end
			if (ctrl.ins && !lt_q) begin
				valid_q <= left_lt ? 1'b1 : left_valid;
			end else if (ctrl.del && ge_q) begin
				valid_q <= right_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt_q) begin
			key_q <= left_lt ? ins_key : left_key;
		end else if (ctrl.del && ge_q) begin
			key_q <= right_key;
		end
	end

	assign key   = key_q;
	assign valid = valid_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

### rtl/core/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted table of nonzero keys with insert, find and delete commands.
// ----------------------------------------------------------------------------
// The table is a row of DEPTH cells, one per entry, kept in ascending order
// with valid entries packed at the low end. In a command's transfer cycle
// all cells compare their key with the incoming key at once, and in the next
// cycle the position is encoded from those flags and the row shifts by one
// place for an insert or delete while the result is registered. A new
// command is taken only once the last one is through and the result side
// keeps up. Reset empties the table at once; no clearing pass is needed.
module sorted_key_table #(
	parameter int unsigned DEPTH    = skc_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS = skc_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skc_pkg::IN_BITS-1:0]   s_tdata,  // cmd[1:0], key[33:2], index[39:34]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skc_pkg::OUT_BITS-1:0]  m_tdata   // status[2:0], position[8:3], entries[15:9]
);
	import skc_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	skc_state_t             state_q;
	skc_ctrl_t              ctrl;
	logic [CMD_BITS-1:0]    cmd_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [INDEX_BITS-1:0]  index_q;
	logic                   kzero_q;
	logic [CW-1:0]          count_q;
	logic                   m_tvalid_q;
	logic [OUT_BITS-1:0]    m_tdata_q;

	logic                   accept;
	logic [KEY_BITS-1:0]    in_key;
	logic [KEY_BITS-1:0]    cell_key   [DEPTH];
	logic                   cell_valid [DEPTH];
	logic                   cell_lt    [DEPTH];
	logic                   cell_eq    [DEPTH];
	logic [DEPTH-1:0]       eq_vec;
	logic [DEPTH-1:0]       bound;
	logic [PW-1:0]          pos;
	logic                   found;
	logic                   do_ins;
	logic                   do_del;
	logic [STATUS_BITS-1:0] status;
	logic [PW-1:0]          res_pos;
	logic [CW-1:0]          count_d;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign in_key   = KEY_BITS'(s_tdata[33:2]);

	assign ctrl.cmp = accept;
	assign ctrl.ins = (state_q == ST_UPD) && do_ins;
	assign ctrl.del = (state_q == ST_UPD) && do_del;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			skc_cell #(.KEY_BITS(KEY_BITS), .CELL_IDX(i)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.cmp_key    (in_key),
				.del_index  (s_tdata[39:34]),
				.ins_key    (key_q),
				.left_key   ('0),
				.left_valid (1'b0),
				.left_lt    (1'b1),
				.right_key  ((DEPTH > 1) ? cell_key[(DEPTH > 1) ? 1 : 0] : '0),
				.right_valid((DEPTH > 1) ? cell_valid[(DEPTH > 1) ? 1 : 0] : 1'b0),
				.key        (cell_key[i]),
				.valid      (cell_valid[i]),
				.lt         (cell_lt[i]),
				.eq         (cell_eq[i])
			);
		end else if (i == DEPTH - 1) begin : g_last
			skc_cell #(.KEY_BITS(KEY_BITS), .CELL_IDX(i)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.cmp_key    (in_key),
				.del_index  (s_tdata[39:34]),
				.ins_key    (key_q),
				.left_key   (cell_key[i-1]),
				.left_valid (cell_valid[i-1]),
				.left_lt    (cell_lt[i-1]),
				.right_key  ('0),
				.right_valid(1'b0),
				.key        (cell_key[i]),
				.valid      (cell_valid[i]),
				.lt         (cell_lt[i]),
				.eq         (cell_eq[i])
			);
		end else begin : g_mid
			skc_cell #(.KEY_BITS(KEY_BITS), .CELL_IDX(i)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.cmp_key    (in_key),
				.del_index  (s_tdata[39:34]),
				.ins_key    (key_q),
				.left_key   (cell_key[i-1]),
				.left_valid (cell_valid[i-1]),
				.left_lt    (cell_lt[i-1]),
				.right_key  (cell_key[i+1]),
				.right_valid(cell_valid[i+1]),
				.key        (cell_key[i]),
				.valid      (cell_valid[i]),
				.lt         (cell_lt[i]),
				.eq         (cell_eq[i])
			);
		end
		assign eq_vec[i] = cell_eq[i];
		assign bound[i]  = !cell_lt[i] && ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i-1]);
	end

	// binary encode of the one-hot insert place
	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (bound[i]) begin
				pos = pos | PW'(i);
			end
		end
	end

	assign found = |eq_vec;

	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		status  = STS_BAD_INDEX;
		res_pos = '0;
		count_d = count_q;
		case (cmd_q)
			CMD_INSERT, CMD_FIND: begin
				if (kzero_q) begin
					status = STS_ZERO_KEY;
				end else if (found) begin
					status  = STS_FOUND;
					res_pos = pos;
				end else if (cmd_q == CMD_FIND) begin
					status = STS_NOT_FOUND;
				end else if (32'(count_q) >= DEPTH) begin
					status = STS_FULL;
				end else begin
					status  = STS_DONE;
					res_pos = pos;
					do_ins  = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			CMD_DELETE: begin
				if (32'(index_q) >= 32'(count_q)) begin
					status = STS_BAD_INDEX;
				end else begin
					status  = STS_DONE;
					do_del  = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				status = STS_BAD_INDEX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q    <= ST_IDLE;
					count_q    <= count_d;
					m_tvalid_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tdata[1:0];
			key_q   <= in_key;
			index_q <= s_tdata[39:34];
			kzero_q <= (in_key == '0);
		end
		if (state_q == ST_UPD) begin
			m_tdata_q <= {ENTRY_BITS'(count_d), POS_BITS'(res_pos), status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key table.
// ----------------------------------------------------------------------------
// Commands are queued up front and driven as stream transfers with random
// gaps, while the result side stalls at random. A behavioural copy of the
// table works out the answer to every accepted command, and each returned
// result is checked field by field against the oldest answer still waiting.
// The stimulus opens with a short directed sequence. It then runs rounds that
// fill the table past full, mix all commands, and drain it back to empty.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import skc_pkg::*;

	localparam int unsigned DEPTH    = DEPTH_DEF;
	localparam int unsigned N_RANDOM = 1600;
	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [INDEX_BITS-1:0] index;
		logic [KEY_W-1:0]      key;
		logic [CMD_BITS-1:0]   cmd;
	} tbl_cmd_t;

	typedef struct packed {
		logic [ENTRY_BITS-1:0]  entries;
		logic [POS_BITS-1:0]    position;
		logic [STATUS_BITS-1:0] status;
	} tbl_rsp_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b1;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_BITS-1:0]  s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_BITS-1:0] m_tdata;

	tbl_cmd_t    pending_cmds[$];
	tbl_rsp_t    awaited_rsps[$];
	tbl_cmd_t    cur_cmd;
	bit          cmd_taken = 1'b0;
	int unsigned in_gap    = 0;
	int unsigned out_gap   = 0;
	int unsigned errors    = 0;
	int unsigned plan_n    = 0;

	// behavioural copy of the table
	logic [KEY_W-1:0] tbl_keys[DEPTH] = '{default: '0};
	int unsigned      tbl_count = 0;

	// generator's own view of the keys held, for picking present keys and indexes
	bit gen_keys[bit [KEY_W-1:0]];

	sorted_key_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic tbl_rsp_t table_update(tbl_cmd_t c);
		int unsigned pos;
		tbl_rsp_t    r;
		r.status   = STS_BAD_INDEX;
		r.position = '0;
		if (c.cmd == CMD_INSERT || c.cmd == CMD_FIND) begin
			if (c.key == '0) begin
				r.status = STS_ZERO_KEY;
			end else begin
				pos = 0;
				while (pos < tbl_count && tbl_keys[pos] < c.key)
					pos++;
				if (pos < tbl_count && tbl_keys[pos] == c.key) begin
					r.status   = STS_FOUND;
					r.position = POS_BITS'(pos);
				end else if (c.cmd == CMD_FIND) begin
					r.status = STS_NOT_FOUND;
				end else if (tbl_count >= DEPTH) begin
					r.status = STS_FULL;
				end else begin
					for (int i = tbl_count; i > pos; i--)
						tbl_keys[i] = tbl_keys[i-1];
					tbl_keys[pos] = c.key;
					tbl_count++;
					r.status   = STS_DONE;
					r.position = POS_BITS'(pos);
				end
			end
		end else if (c.cmd == CMD_DELETE && c.index < tbl_count) begin
			for (int i = c.index; i + 1 < tbl_count; i++)
				tbl_keys[i] = tbl_keys[i+1];
			tbl_keys[tbl_count-1] = '0;
			tbl_count--;
			r.status = STS_DONE;
		end
		r.entries = ENTRY_BITS'(tbl_count);
		return r;
	endfunction

	function automatic bit [KEY_W-1:0] nth_key(int unsigned n);
		bit [KEY_W-1:0] k;
		int unsigned    i;
		i = 0;
		void'(gen_keys.first(k));
		while (i < n) begin
			void'(gen_keys.next(k));
			i++;
		end
		return k;
	endfunction

	function automatic bit [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40 && gen_keys.num() > 0)
			return nth_key($urandom_range(0, gen_keys.num() - 1));
		else if (r < 70)
			return KEY_W'($urandom_range(1, 300));
		else if (r < 90)
			return KEY_W'($urandom);
		else if (r < 95) begin
			case ($urandom_range(0, 3))
				0:       return 32'h0000_0001;
				1:       return 32'hFFFF_FFFF;
				2:       return 32'h8000_0000;
				default: return 32'hFFFF_FFFE;
			endcase
		end
		return '0;
	endfunction

	task automatic add_item(logic [CMD_BITS-1:0] cmd, logic [KEY_W-1:0] key,
			logic [INDEX_BITS-1:0] index);
		tbl_cmd_t c;
		c.cmd   = cmd;
		c.key   = key;
		c.index = index;
		pending_cmds.push_back(c);
		plan_n++;
		if (cmd == CMD_INSERT && key != '0 && !gen_keys.exists(key) && gen_keys.num() < DEPTH)
			gen_keys[key] = 1'b1;
		if (cmd == CMD_DELETE && index < gen_keys.num())
			gen_keys.delete(nth_key(index));
	endtask

	task automatic plan_item(int unsigned w_ins, int unsigned w_find, int unsigned w_del);
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		n = gen_keys.num();
		if (r < w_ins)
			add_item(CMD_INSERT, pick_key(), INDEX_BITS'($urandom));
		else if (r < w_ins + w_find)
			add_item(CMD_FIND, pick_key(), INDEX_BITS'($urandom));
		else if (r < w_ins + w_find + w_del)
			add_item(CMD_DELETE, KEY_W'($urandom),
				(n > 0 && $urandom_range(0, 7) != 0) ? INDEX_BITS'($urandom_range(0, n - 1))
				                                     : INDEX_BITS'($urandom_range(0, DEPTH - 1)));
		else
			add_item(CMD_UNUSED, KEY_W'($urandom), INDEX_BITS'($urandom));
	endtask

	// gaps only while plenty is queued, with calm stretches in between
	function automatic bit idling_allowed();
		return pending_cmds.size() > 200 && pending_cmds.size() % 300 >= 60;
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			awaited_rsps.push_back(table_update(cur_cmd));
			cmd_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || cmd_taken)) begin
			cmd_taken = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cur_cmd = pending_cmds.pop_front();
				s_tdata  <= cur_cmd;
				s_tvalid <= 1'b1;
				if (idling_allowed() && $urandom_range(0, 4) == 0)
					in_gap = $urandom_range(1, 10);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (idling_allowed() && $urandom_range(0, 5) == 0)
				out_gap = $urandom_range(1, 10);
		end
	end

	always @(posedge clk) begin
		tbl_rsp_t got;
		tbl_rsp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (awaited_rsps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d position %0d entries %0d",
						got.status, got.position, got.entries);
			end else begin
				want = awaited_rsps.pop_front();
				if (got.status !== want.status || got.position !== want.position ||
						got.entries !== want.entries) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at %0t: status %0d/%0d position %0d/%0d entries %0d/%0d (expected/actual)",
							$realtime, want.status, got.status, want.position, got.position,
							want.entries, got.entries);
				end
			end
		end
	end

	initial begin
		#1 arst_n = 1'b0;

		// empty table, zero keys, unused command
		add_item(CMD_FIND,   32'd5,          6'd0);
		add_item(CMD_INSERT, 32'd0,          6'd0);
		add_item(CMD_FIND,   32'd0,          6'd63);
		add_item(CMD_DELETE, 32'd0,          6'd0);
		add_item(CMD_UNUSED, 32'd0,          6'd0);
		// extremes and a present key
		add_item(CMD_INSERT, 32'hFFFF_FFFF,  6'd63);
		add_item(CMD_INSERT, 32'h0000_0001,  6'd0);
		add_item(CMD_INSERT, 32'h8000_0000,  6'd21);
		add_item(CMD_INSERT, 32'd40,         6'd42);
		add_item(CMD_INSERT, 32'h0000_0001,  6'd0);
		add_item(CMD_FIND,   32'hFFFF_FFFF,  6'd0);
		add_item(CMD_FIND,   32'd2,          6'd63);
		// deletes: index at count, out of range, middle, last, first
		add_item(CMD_DELETE, 32'hFFFF_FFFF,  6'd4);
		add_item(CMD_DELETE, 32'd0,          6'd63);
		add_item(CMD_DELETE, 32'd0,          6'd1);
		add_item(CMD_DELETE, 32'hFFFF_FFFF,  6'd2);
		add_item(CMD_INSERT, 32'd20,         6'd0);
		add_item(CMD_DELETE, 32'd0,          6'd0);
		add_item(CMD_UNUSED, 32'hFFFF_FFFF,  6'd63);

		plan_n = 0;
		while (plan_n < N_RANDOM) begin
			while (gen_keys.num() < DEPTH && plan_n < N_RANDOM)
				plan_item(70, 15, 10);
			repeat (12) plan_item(80, 10, 5);
			repeat (40) plan_item(35, 35, 25);
			while (gen_keys.num() > 0 && plan_n < N_RANDOM)
				plan_item(10, 10, 75);
			repeat (4) plan_item(20, 30, 45);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || s_tvalid)
			@(posedge clk);
		while (awaited_rsps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0 && awaited_rsps.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule
